[rtl/sd_card_spi_init_sequencer_unit_assert.svh]
// assertion macros for the sd card spi init sequencer
// expects clk and arst_n in the scope of use
`ifndef SD_CARD_SPI_INIT_SEQUENCER_UNIT_ASSERT_SVH
`define SD_CARD_SPI_INIT_SEQUENCER_UNIT_ASSERT_SVH

// same-cycle implication
`define SDI_ASSERT_IMP(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error("sdinit assertion failed");

// next-cycle implication
`define SDI_ASSERT_NXT(lbl, ant, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error("sdinit assertion failed");

`endif

[rtl/sdinit_pkg.sv]
// constants, codes and command frame table for the sd card spi init sequencer
// no dependencies
`timescale 1ns / 1ps

package sdinit_pkg;

	localparam logic [2:0] SEL_GO_IDLE  = 3'd0;
	localparam logic [2:0] SEL_IF_COND  = 3'd1;
	localparam logic [2:0] SEL_APP      = 3'd2;
	localparam logic [2:0] SEL_OP_V1    = 3'd3;
	localparam logic [2:0] SEL_OP_V2    = 3'd4;
	localparam logic [2:0] SEL_BLOCKLEN = 3'd5;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_NO_IDLE  = 3'd1;
	localparam logic [2:0] ERR_V1_OP    = 3'd2;
	localparam logic [2:0] ERR_ECHO     = 3'd3;
	localparam logic [2:0] ERR_V2_OP    = 3'd4;
	localparam logic [2:0] ERR_BLOCKLEN = 3'd5;

	localparam logic [1:0] VER_UNKNOWN = 2'd0;
	localparam logic [1:0] VER_1       = 2'd1;
	localparam logic [1:0] VER_2       = 2'd2;

	localparam logic [1:0] REG_POWER_UP_WAIT     = 2'd0;
	localparam logic [1:0] REG_DUMMY_CLOCK_COUNT = 2'd1;
	localparam logic [1:0] REG_IDLE_ATTEMPTS     = 2'd2;
	localparam logic [1:0] REG_REPLY_POLL_BYTES  = 2'd3;

	localparam logic [7:0] REPLY_IDLE   = 8'h01;
	localparam logic [7:0] REPLY_READY  = 8'h00;
	localparam logic [7:0] BYTE_ONES    = 8'hFF;
	localparam logic [7:0] ECHO_PATTERN = 8'hAA;
	localparam logic [3:0] ECHO_VOLTAGE = 4'h1;
	localparam logic [3:0] FRAME_BYTES  = 4'd7;
	localparam logic [3:0] ECHO_COUNT   = 4'd4;

	localparam logic [7:0] CMD_BASE = 8'h40;

	// command byte k (1..6) of frame sel, 0xFF outside the frame
	function automatic logic [7:0] frame_byte(input logic [2:0] sel, input logic [3:0] k);
		logic [2:0] s;
		logic [7:0] b;
		s = (sel > SEL_BLOCKLEN) ? SEL_BLOCKLEN : sel;
		b = BYTE_ONES;
		case (k)
			4'd1: begin
				case (s)
					SEL_GO_IDLE: b = CMD_BASE | 8'd0;
					SEL_IF_COND: b = CMD_BASE | 8'd8;
					SEL_APP:     b = CMD_BASE | 8'd55;
					SEL_OP_V1:   b = CMD_BASE | 8'd41;
					SEL_OP_V2:   b = CMD_BASE | 8'd41;
					default:     b = CMD_BASE | 8'd16;
				endcase
			end
			4'd2: b = (s == SEL_OP_V2) ? 8'h40 : 8'h00;
			4'd3: b = 8'h00;
			4'd4: begin
				case (s)
					SEL_IF_COND:  b = 8'h01;
					SEL_BLOCKLEN: b = 8'h02;
					default:      b = 8'h00;
				endcase
			end
			4'd5: b = (s == SEL_IF_COND) ? ECHO_PATTERN : 8'h00;
			4'd6: begin
				case (s)
					SEL_GO_IDLE: b = 8'h94 | 8'h01;
					SEL_IF_COND: b = 8'h86 | 8'h01;
					default:     b = 8'h01;
				endcase
			end
			default: b = BYTE_ONES;
		endcase
		return b;
	endfunction

endpackage

[rtl/sd_card_spi_init_sequencer_unit.sv]
// Path: an accepted word passes the input register, then the result register. Throughput:
// one word per cycle while results are taken; a stalled result still lets one more word in.
// Each word is one spi bit slot; the sequencer state advances once per word.
// Reset (arst_n low, asynchronous): sequencer idle, config registers at their defaults
// (wait 1000000, dummy clocks 80, idle attempts 6, poll bytes 10), no words held.
// depends on sdinit_pkg and sd_card_spi_init_sequencer_unit_assert.svh
`timescale 1ns / 1ps
`include "sd_card_spi_init_sequencer_unit_assert.svh"

module sd_card_spi_init_sequencer_unit import sdinit_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic        miso,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        chip_select,
	output logic        mosi,
	output logic        clock_pulse,
	output logic        busy_res,
	output logic        done_res,
	output logic        success,
	output logic [1:0]  card_version,
	output logic [2:0]  error_code,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_wdata
);

	typedef enum logic [2:0] {
		PH_IDLE, PH_WAIT, PH_DUMMY, PH_SEND, PH_POLL, PH_ECHO, PH_STOP
	} phase_t;

	// config registers
	logic [23:0] power_up_wait_q;
	logic [7:0]  dummy_clock_count_q;
	logic [3:0]  idle_attempts_q;
	logic [3:0]  reply_poll_bytes_q;

	// input stage
	logic valid_s1, action_s1, miso_s1;

	// sequencer state
	phase_t      phase_q, phase_d;
	logic [2:0]  sel_q, sel_d;
	logic [2:0]  bit_q, bit_d;
	logic [3:0]  byte_q, byte_d;
	logic [7:0]  oshift_q, oshift_d;
	logic [7:0]  ishift_q, ishift_d;
	logic [7:0]  reply_q, reply_d;
	logic [15:0] echo_q, echo_d;
	logic [3:0]  attempt_q, attempt_d;
	logic [23:0] wait_q, wait_d;
	logic [1:0]  version_q, version_d;
	logic [2:0]  error_q, error_d;

	// result stage
	logic       out_valid_q;
	logic       cs_q, mosi_q, pulse_q, busy_q, done_q, ok_q;
	logic [1:0] ver_out_q;
	logic [2:0] err_out_q;

	logic       cs_d, mosi_d, pulse_d, done_d, ok_d;
	logic       go_frame, fin;
	logic [2:0] go_sel, fin_code;
	logic [3:0] polls, lim;
	logic       advance;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign polls    = (reply_poll_bytes_q == 4'd0) ? 4'd1 : reply_poll_bytes_q;
	assign lim      = (idle_attempts_q == 4'd0) ? 4'd1 : idle_attempts_q;

	always_comb begin
		phase_d   = phase_q;
		sel_d     = sel_q;
		bit_d     = bit_q;
		byte_d    = byte_q;
		oshift_d  = oshift_q;
		ishift_d  = ishift_q;
		reply_d   = reply_q;
		echo_d    = echo_q;
		attempt_d = attempt_q;
		wait_d    = wait_q;
		version_d = version_q;
		error_d   = error_q;
		cs_d      = 1'b1;
		mosi_d    = 1'b1;
		pulse_d   = 1'b0;
		done_d    = 1'b0;
		ok_d      = 1'b0;
		go_frame  = 1'b0;
		go_sel    = SEL_GO_IDLE;
		fin       = 1'b0;
		fin_code  = ERR_NONE;

		if (phase_q == PH_IDLE) begin
			if (action_s1) begin
				phase_d   = PH_WAIT;
				wait_d    = power_up_wait_q;
				version_d = VER_UNKNOWN;
				error_d   = ERR_NONE;
				attempt_d = 4'd0;
				reply_d   = BYTE_ONES;
				echo_d    = 16'd0;
			end
		end else begin
			if (phase_d == PH_WAIT && wait_d == 24'd0) begin
				phase_d = PH_DUMMY;
				wait_d  = {16'd0, dummy_clock_count_q};
			end
			if (phase_d == PH_DUMMY && wait_d == 24'd0) begin
				sel_d    = SEL_GO_IDLE;
				byte_d   = 4'd0;
				bit_d    = 3'd0;
				oshift_d = BYTE_ONES;
				phase_d  = PH_SEND;
			end
			unique case (phase_d)
				PH_WAIT: begin
					wait_d = wait_d - 24'd1;
				end
				PH_DUMMY: begin
					wait_d  = wait_d - 24'd1;
					pulse_d = 1'b1;
				end
				PH_SEND: begin
					cs_d     = 1'b0;
					pulse_d  = 1'b1;
					mosi_d   = oshift_d[7];
					oshift_d = {oshift_d[6:0], 1'b0};
					bit_d    = bit_d + 3'd1;
					if (bit_d == 3'd0) begin
						byte_d = byte_d + 4'd1;
						if (byte_d >= FRAME_BYTES) begin
							phase_d  = PH_POLL;
							byte_d   = 4'd0;
							ishift_d = 8'd0;
						end else begin
							oshift_d = frame_byte(sel_d, byte_d);
						end
					end
				end
				PH_POLL: begin
					cs_d     = 1'b0;
					pulse_d  = 1'b1;
					ishift_d = {ishift_d[6:0], miso_s1};
					bit_d    = bit_d + 3'd1;
					if (bit_d == 3'd0) begin
						if (!ishift_d[7]) begin
							reply_d = ishift_d;
							byte_d  = 4'd0;
							phase_d = (sel_d == SEL_IF_COND) ? PH_ECHO : PH_STOP;
						end else begin
							byte_d = byte_d + 4'd1;
							if (byte_d >= polls) begin
								reply_d = BYTE_ONES;
								phase_d = PH_STOP;
							end
						end
					end
				end
				PH_ECHO: begin
					cs_d     = 1'b0;
					pulse_d  = 1'b1;
					ishift_d = {ishift_d[6:0], miso_s1};
					bit_d    = bit_d + 3'd1;
					if (bit_d == 3'd0) begin
						echo_d = {echo_d[7:0], ishift_d};
						byte_d = byte_d + 4'd1;
						if (byte_d >= ECHO_COUNT) begin
							phase_d = PH_STOP;
						end
					end
				end
				PH_STOP: begin
					case (sel_d)
						SEL_GO_IDLE: begin
							if (reply_d == REPLY_IDLE) begin
								go_frame = 1'b1;
								go_sel   = SEL_IF_COND;
							end else begin
								attempt_d = attempt_d + 4'd1;
								if (attempt_d >= lim) begin
									fin      = 1'b1;
									fin_code = ERR_NO_IDLE;
								end else begin
									go_frame = 1'b1;
									go_sel   = SEL_GO_IDLE;
								end
							end
						end
						SEL_IF_COND: begin
							if (reply_d == REPLY_READY || reply_d == REPLY_IDLE) begin
								if (echo_d[11:8] != ECHO_VOLTAGE || echo_d[7:0] != ECHO_PATTERN) begin
									fin      = 1'b1;
									fin_code = ERR_ECHO;
								end else begin
									version_d = VER_2;
									go_frame  = 1'b1;
									go_sel    = SEL_APP;
								end
							end else begin
								version_d = VER_1;
								go_frame  = 1'b1;
								go_sel    = SEL_APP;
							end
						end
						SEL_APP: begin
							go_frame = 1'b1;
							go_sel   = (version_d == VER_1) ? SEL_OP_V1 : SEL_OP_V2;
						end
						SEL_OP_V1, SEL_OP_V2: begin
							if (reply_d == REPLY_READY) begin
								go_frame = 1'b1;
								go_sel   = SEL_BLOCKLEN;
							end else if (reply_d == REPLY_IDLE) begin
								go_frame = 1'b1;
								go_sel   = SEL_APP;
							end else begin
								fin      = 1'b1;
								fin_code = (sel_d == SEL_OP_V1) ? ERR_V1_OP : ERR_V2_OP;
							end
						end
						default: begin
							fin      = 1'b1;
							fin_code = (reply_d == REPLY_READY) ? ERR_NONE : ERR_BLOCKLEN;
						end
					endcase
					if (go_frame) begin
						sel_d    = go_sel;
						byte_d   = 4'd0;
						bit_d    = 3'd0;
						oshift_d = BYTE_ONES;
						phase_d  = PH_SEND;
					end
					if (fin) begin
						phase_d = PH_IDLE;
						error_d = fin_code;
						if (fin_code != ERR_NONE) begin
							version_d = VER_UNKNOWN;
						end
						done_d = 1'b1;
						ok_d   = (fin_code == ERR_NONE);
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_up_wait_q     <= 24'd1000000;
			dummy_clock_count_q <= 8'd80;
			idle_attempts_q     <= 4'd6;
			reply_poll_bytes_q  <= 4'd10;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POWER_UP_WAIT:     power_up_wait_q     <= cfg_wdata;
				REG_DUMMY_CLOCK_COUNT: dummy_clock_count_q <= cfg_wdata[7:0];
				REG_IDLE_ATTEMPTS:     idle_attempts_q     <= cfg_wdata[3:0];
				REG_REPLY_POLL_BYTES:  reply_poll_bytes_q  <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			miso_s1   <= miso;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			sel_q       <= SEL_GO_IDLE;
			bit_q       <= 3'd0;
			byte_q      <= 4'd0;
			oshift_q    <= BYTE_ONES;
			ishift_q    <= 8'd0;
			reply_q     <= BYTE_ONES;
			echo_q      <= 16'd0;
			attempt_q   <= 4'd0;
			wait_q      <= 24'd0;
			version_q   <= VER_UNKNOWN;
			error_q     <= ERR_NONE;
			out_valid_q <= 1'b0;
			cs_q        <= 1'b1;
			mosi_q      <= 1'b1;
			pulse_q     <= 1'b0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			ok_q        <= 1'b0;
			ver_out_q   <= VER_UNKNOWN;
			err_out_q   <= ERR_NONE;
		end else if (advance) begin
			phase_q     <= phase_d;
			sel_q       <= sel_d;
			bit_q       <= bit_d;
			byte_q      <= byte_d;
			oshift_q    <= oshift_d;
			ishift_q    <= ishift_d;
			reply_q     <= reply_d;
			echo_q      <= echo_d;
			attempt_q   <= attempt_d;
			wait_q      <= wait_d;
			version_q   <= version_d;
			error_q     <= error_d;
			out_valid_q <= 1'b1;
			cs_q        <= cs_d;
			mosi_q      <= mosi_d;
			pulse_q     <= pulse_d;
			busy_q      <= (phase_d != PH_IDLE);
			done_q      <= done_d;
			ok_q        <= ok_d;
			ver_out_q   <= version_d;
			err_out_q   <= error_d;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign chip_select  = cs_q;
	assign mosi         = mosi_q;
	assign clock_pulse  = pulse_q;
	assign busy_res     = busy_q;
	assign done_res     = done_q;
	assign success      = ok_q;
	assign card_version = ver_out_q;
	assign error_code   = err_out_q;

	`SDI_ASSERT_IMP(a_done_not_busy, out_valid_q && done_q, !busy_q)
	`SDI_ASSERT_IMP(a_success_clean, out_valid_q && ok_q, done_q && err_out_q == ERR_NONE)
	`SDI_ASSERT_IMP(a_select_when_busy, out_valid_q && !cs_q, busy_q && pulse_q)
	`SDI_ASSERT_IMP(a_err_clears_ver, out_valid_q && err_out_q != ERR_NONE, ver_out_q == VER_UNKNOWN)
	`SDI_ASSERT_NXT(a_state_idle_frame, advance && phase_q == PH_IDLE && !action_s1, phase_q == PH_IDLE)

endmodule

[tb/sd_init_tb_pkg.sv]
// slot word type and scoreboard class for the sd card spi init sequencer testbench
// the class steps its own copy of the sequencer one bit slot per accepted word
// depends on sdinit_pkg
`timescale 1ns / 1ps

package sd_init_tb_pkg;
	import sdinit_pkg::*;

	typedef enum logic [2:0] {
		SEQ_IDLE, SEQ_WAIT, SEQ_DUMMY, SEQ_SEND, SEQ_POLL, SEQ_ECHO, SEQ_STOP
	} seq_phase_t;

	typedef struct packed {
		logic       chip_sel;
		logic       data_out;
		logic       sclk_pulse;
		logic       busy;
		logic       done;
		logic       ok;
		logic [1:0] card_ver;
		logic [2:0] err_code;
	} slot_t;

	class init_slot_scoreboard;
		logic [23:0] power_wait;
		logic [7:0]  dummy_clocks;
		logic [3:0]  idle_attempts;
		logic [3:0]  poll_bytes;

		seq_phase_t  ph;
		logic [2:0]  sel;
		logic [2:0]  bit_cnt;
		logic [3:0]  byte_cnt;
		logic [7:0]  out_sr;
		logic [7:0]  in_sr;
		logic [7:0]  reply;
		logic [15:0] echo;
		logic [3:0]  attempts;
		logic [23:0] wait_cnt;
		logic [1:0]  ver_reg;
		logic [2:0]  err_reg;
		slot_t       pending[$];
		int          fails;

		function new();
			power_wait = 24'd1000000;
			dummy_clocks = 8'd80;
			idle_attempts = 4'd6;
			poll_bytes = 4'd10;
			ph = SEQ_IDLE;
			sel = SEL_GO_IDLE;
			bit_cnt = '0;
			byte_cnt = '0;
			out_sr = BYTE_ONES;
			in_sr = '0;
			reply = BYTE_ONES;
			echo = '0;
			attempts = '0;
			wait_cnt = '0;
			ver_reg = VER_UNKNOWN;
			err_reg = ERR_NONE;
			fails = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [23:0] val);
			case (idx)
				REG_POWER_UP_WAIT:     power_wait = val;
				REG_DUMMY_CLOCK_COUNT: dummy_clocks = val[7:0];
				REG_IDLE_ATTEMPTS:     idle_attempts = val[3:0];
				default:               poll_bytes = val[3:0];
			endcase
		endfunction

		// byte k (1..6) of the command frame, ones outside it
		function logic [7:0] cmd_byte(logic [2:0] s, logic [3:0] k);
			logic [47:0] w;
			if (k == 0 || k > 6)
				return BYTE_ONES;
			case (s)
				SEL_GO_IDLE: w = 48'h40_00_00_00_00_95;
				SEL_IF_COND: w = 48'h48_00_00_01_AA_87;
				SEL_APP:     w = 48'h77_00_00_00_00_01;
				SEL_OP_V1:   w = 48'h69_00_00_00_00_01;
				SEL_OP_V2:   w = 48'h69_40_00_00_00_01;
				default:     w = 48'h50_00_00_02_00_01;
			endcase
			return w[8 * (6 - k) +: 8];
		endfunction

		function void start_frame(logic [2:0] s);
			sel = s;
			byte_cnt = '0;
			bit_cnt = '0;
			out_sr = BYTE_ONES;
			ph = SEQ_SEND;
		endfunction

		function slot_t emit(bit cs, bit mo, bit pulse, bit done, bit ok);
			slot_t s;
			s.chip_sel = cs;
			s.data_out = mo;
			s.sclk_pulse = pulse;
			s.busy = (ph != SEQ_IDLE);
			s.done = done;
			s.ok = ok;
			s.card_ver = ver_reg;
			s.err_code = err_reg;
			return s;
		endfunction

		function void note_tick(bit act, bit din);
			logic [3:0] polls;
			logic [3:0] lim;
			logic [2:0] code;
			bit         ended;
			bit         mo;
			slot_t      res;
			polls = (poll_bytes == 0) ? 4'd1 : poll_bytes;
			lim = (idle_attempts == 0) ? 4'd1 : idle_attempts;
			if (ph == SEQ_IDLE) begin
				if (act) begin
					ph = SEQ_WAIT;
					wait_cnt = power_wait;
					ver_reg = VER_UNKNOWN;
					err_reg = ERR_NONE;
					attempts = '0;
					reply = BYTE_ONES;
					echo = '0;
				end
				pending.push_back(emit(1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
				return;
			end
			if (ph == SEQ_WAIT && wait_cnt == 0) begin
				ph = SEQ_DUMMY;
				wait_cnt = 24'(dummy_clocks);
			end
			if (ph == SEQ_DUMMY && wait_cnt == 0)
				start_frame(SEL_GO_IDLE);
			case (ph)
				SEQ_WAIT: begin
					wait_cnt = wait_cnt - 24'd1;
					res = emit(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
				end
				SEQ_DUMMY: begin
					wait_cnt = wait_cnt - 24'd1;
					res = emit(1'b1, 1'b1, 1'b1, 1'b0, 1'b0);
				end
				SEQ_SEND: begin
					mo = out_sr[7];
					out_sr = {out_sr[6:0], 1'b0};
					bit_cnt = bit_cnt + 3'd1;
					if (bit_cnt == 0) begin
						byte_cnt = byte_cnt + 4'd1;
						if (byte_cnt >= FRAME_BYTES) begin
							ph = SEQ_POLL;
							byte_cnt = '0;
							in_sr = '0;
						end else begin
							out_sr = cmd_byte(sel, byte_cnt);
						end
					end
					res = emit(1'b0, mo, 1'b1, 1'b0, 1'b0);
				end
				SEQ_POLL: begin
					in_sr = {in_sr[6:0], din};
					bit_cnt = bit_cnt + 3'd1;
					if (bit_cnt == 0) begin
						if (!in_sr[7]) begin
							reply = in_sr;
							byte_cnt = '0;
							ph = (sel == SEL_IF_COND) ? SEQ_ECHO : SEQ_STOP;
						end else begin
							byte_cnt = byte_cnt + 4'd1;
							if (byte_cnt >= polls) begin
								reply = BYTE_ONES;
								ph = SEQ_STOP;
							end
						end
					end
					res = emit(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
				end
				SEQ_ECHO: begin
					in_sr = {in_sr[6:0], din};
					bit_cnt = bit_cnt + 3'd1;
					if (bit_cnt == 0) begin
						echo = {echo[7:0], in_sr};
						byte_cnt = byte_cnt + 4'd1;
						if (byte_cnt >= ECHO_COUNT)
							ph = SEQ_STOP;
					end
					res = emit(1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
				end
				default: begin
					// deselect slot: judge the reply of the finished frame
					ended = 1'b0;
					code = ERR_NONE;
					case (sel)
						SEL_GO_IDLE: begin
							if (reply == REPLY_IDLE) begin
								start_frame(SEL_IF_COND);
							end else begin
								attempts = attempts + 4'd1;
								if (attempts >= lim) begin
									ended = 1'b1;
									code = ERR_NO_IDLE;
								end else begin
									start_frame(SEL_GO_IDLE);
								end
							end
						end
						SEL_IF_COND: begin
							if (reply == REPLY_READY || reply == REPLY_IDLE) begin
								if (echo[11:8] != ECHO_VOLTAGE || echo[7:0] != ECHO_PATTERN) begin
									ended = 1'b1;
									code = ERR_ECHO;
								end else begin
									ver_reg = VER_2;
								end
							end else begin
								ver_reg = VER_1;
							end
							if (!ended)
								start_frame(SEL_APP);
						end
						SEL_APP: start_frame((ver_reg == VER_1) ? SEL_OP_V1 : SEL_OP_V2);
						SEL_OP_V1, SEL_OP_V2: begin
							if (reply == REPLY_READY) begin
								start_frame(SEL_BLOCKLEN);
							end else if (reply == REPLY_IDLE) begin
								start_frame(SEL_APP);
							end else begin
								ended = 1'b1;
								code = (sel == SEL_OP_V1) ? ERR_V1_OP : ERR_V2_OP;
							end
						end
						default: begin
							ended = 1'b1;
							code = (reply == REPLY_READY) ? ERR_NONE : ERR_BLOCKLEN;
						end
					endcase
					if (ended) begin
						ph = SEQ_IDLE;
						err_reg = code;
						if (code != ERR_NONE)
							ver_reg = VER_UNKNOWN;
						res = emit(1'b1, 1'b1, 1'b0, 1'b1, code == ERR_NONE);
					end else begin
						res = emit(1'b1, 1'b1, 1'b0, 1'b0, 1'b0);
					end
				end
			endcase
			pending.push_back(res);
		endfunction

		function void compare(string name, int want, int got);
			if (want != got) begin
				$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
				fails++;
			end
		endfunction

		function void check_slot(slot_t got);
			slot_t want;
			if (pending.size() == 0) begin
				$display("%0t ns: result word with nothing expected, got %h", $time, got);
				fails++;
				return;
			end
			want = pending.pop_front();
			compare("chip_select", want.chip_sel, got.chip_sel);
			compare("mosi", want.data_out, got.data_out);
			compare("clock_pulse", want.sclk_pulse, got.sclk_pulse);
			compare("busy_res", want.busy, got.busy);
			compare("done_res", want.done, got.done);
			compare("success", want.ok, got.ok);
			compare("card_version", want.card_ver, got.card_ver);
			compare("error_code", want.err_code, got.err_code);
		endfunction
	endclass

endpackage

[tb/sd_card_spi_init_sequencer_unit_test.sv]
// testbench top for sd_card_spi_init_sequencer_unit: a card responder shapes miso per frame,
// both sides idle at random, every result word is checked against the scoreboard class
// depends on sdinit_pkg, sd_init_tb_pkg and the unit under test
`timescale 1ns / 1ps

module sd_card_spi_init_sequencer_unit_test;
	import sdinit_pkg::*;
	import sd_init_tb_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        action;
	logic        miso;
	logic        out_valid;
	logic        out_ready;
	logic        chip_select;
	logic        mosi;
	logic        clock_pulse;
	logic        busy_res;
	logic        done_res;
	logic        success;
	logic [1:0]  card_version;
	logic [2:0]  error_code;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_wdata;

	init_slot_scoreboard sb;
	bit   card_bits[$];
	int   words_sent = 0;
	bit   held = 1'b0;
	logic calm;

	// stretch with no idling on either side
	assign calm = (words_sent >= 900) && (words_sent < 1100);

	sd_card_spi_init_sequencer_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.miso(miso),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.chip_select(chip_select),
		.mosi(mosi),
		.clock_pulse(clock_pulse),
		.busy_res(busy_res),
		.done_res(done_res),
		.success(success),
		.card_version(card_version),
		.error_code(error_code),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void push_byte(input logic [7:0] b);
		for (int i = 7; i >= 0; i--)
			card_bits.push_back(b[i]);
	endfunction

	// reply bytes for the frame now polling: filler, reply, echo for cmd8
	function automatic void plan_reply();
		int         polls;
		int         fill;
		int         pick;
		logic [7:0] ans;
		polls = (sb.poll_bytes == 0) ? 1 : int'(sb.poll_bytes);
		if ($urandom_range(99) < 10)
			return;
		fill = ($urandom_range(99) < 10) ? polls : $urandom_range(polls - 1);
		repeat (fill)
			push_byte(($urandom_range(99) < 70) ? BYTE_ONES : {1'b1, 7'($urandom_range(127))});
		if (fill == polls)
			return;
		ans = {1'b0, 7'($urandom_range(127))};
		pick = $urandom_range(99);
		case (sb.sel)
			SEL_GO_IDLE: if (pick < 70) ans = REPLY_IDLE;
			SEL_IF_COND: begin
				if (pick < 60)
					ans = $urandom_range(1) ? REPLY_IDLE : REPLY_READY;
				else if (pick < 80)
					ans = 8'h05;
			end
			SEL_APP: if (pick < 80) ans = REPLY_IDLE;
			SEL_OP_V1, SEL_OP_V2: begin
				if (pick < 45)
					ans = REPLY_READY;
				else if (pick < 85)
					ans = REPLY_IDLE;
			end
			default: if (pick < 75) ans = REPLY_READY;
		endcase
		push_byte(ans);
		if (sb.sel == SEL_IF_COND) begin
			pick = $urandom_range(99);
			push_byte(8'($urandom_range(255)));
			push_byte(8'($urandom_range(255)));
			push_byte((pick >= 70 && pick < 85) ? 8'($urandom_range(255)) : 8'h01);
			push_byte((pick >= 85) ? 8'($urandom_range(255)) : ECHO_PATTERN);
		end
	endfunction

	function automatic bit next_miso();
		if (sb.ph != SEQ_POLL && sb.ph != SEQ_ECHO) begin
			card_bits.delete();
			return 1'($urandom_range(1));
		end
		if (sb.ph == SEQ_POLL && sb.byte_cnt == 0 && sb.bit_cnt == 0 && card_bits.size() == 0)
			plan_reply();
		if (card_bits.size() == 0)
			return 1'($urandom_range(1));
		return card_bits.pop_front();
	endfunction

	task automatic send_word(input bit a, input bit m);
		while (!calm && $urandom_range(99) < 35) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		miso <= m;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_tick(a, m);
		words_sent++;
	endtask

	task automatic run_random(input int count);
		bit a;
		bit m;
		repeat (count) begin
			if (sb.ph == SEQ_IDLE)
				a = ($urandom_range(99) < 75);
			else
				a = ($urandom_range(99) < 3);
			m = next_miso();
			send_word(a, m);
		end
	endtask

	task automatic configure(input logic [23:0] pw, input logic [7:0] dc,
			input logic [3:0] ia, input logic [3:0] rp);
		logic [1:0]  idx [5];
		logic [23:0] val [5];
		idx = '{REG_POWER_UP_WAIT, REG_POWER_UP_WAIT, REG_DUMMY_CLOCK_COUNT,
			REG_IDLE_ATTEMPTS, REG_REPLY_POLL_BYTES};
		val = '{24'hFFFFFF, pw, 24'(dc), 24'(ia), 24'(rp)};
		for (int i = 0; i < 5; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
			sb.set_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		sb = new();
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		action <= 1'b0;
		miso <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_POWER_UP_WAIT;
		cfg_wdata <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero attempt and poll counts, start and a start while busy
		configure(24'd2, 8'd1, 4'd0, 4'd0);
		send_word(1'b0, 1'b0);
		send_word(1'b0, 1'b1);
		send_word(1'b1, 1'b0);
		send_word(1'b1, 1'b1);
		send_word(1'b0, 1'b1);
		run_random(195);
		settle();

		configure(24'd1, 8'd255, 4'd15, 4'd15);
		run_random(200);
		settle();

		configure(24'd0, 8'd0, 4'd1, 4'd1);
		run_random(200);
		settle();

		repeat (5) begin
			configure(24'($urandom_range(40)), 8'($urandom_range(12)),
				4'($urandom_range(15)), 4'($urandom_range(15)));
			run_random(200);
			settle();
		end

		repeat (10) @(posedge clk);
		if (sb.fails == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		out_ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && words_sent >= 450) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			out_ready <= calm || ($urandom_range(99) >= 35);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_slot(slot_t'({chip_select, mosi, clock_pulse, busy_res, done_res,
				success, card_version, error_code}));
	end

	initial begin
		#3_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

[sd_card_spi_init_sequencer_unit.f]
+incdir+rtl
rtl/sdinit_pkg.sv
rtl/sd_card_spi_init_sequencer_unit.sv
tb/sd_init_tb_pkg.sv
tb/sd_card_spi_init_sequencer_unit_test.sv
